>>> src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int PRIO_W        = 32;
  localparam int TAG_W         = 16;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ   = 2'd0,
    MODE_DEQ   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;  // capture the accepted operation
    logic exec;  // apply it to the array and load the result register
  } cmd_t;

endpackage

>>> src/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// Operation channel: valid/ready with mode, priority and tag.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::MODE_W-1:0]   mode;
  logic signed [spq_pkg::PRIO_W-1:0] priority_in;
  logic [spq_pkg::TAG_W-1:0]    tag_in;

  modport source (output valid, output mode, output priority_in, output tag_in,
                  input ready);
  modport sink   (input valid, input mode, input priority_in, input tag_in,
                  output ready);
endinterface

>>> src/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// Result channel: valid/ready with front entry, count and status.
// ----------------------------------------------------------------------------
interface spq_rsp_if #(
  parameter int CountW = 7
);
  logic                               valid;
  logic                               ready;
  logic signed [spq_pkg::PRIO_W-1:0]  priority_out;
  logic [spq_pkg::TAG_W-1:0]          tag_out;
  logic [CountW-1:0]                  count;
  logic [spq_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output priority_out, output tag_out,
                  output count, output status, input ready);
  modport sink   (input valid, input priority_out, input tag_out,
                  input count, input status, output ready);
endinterface

>>> src/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Two-state sequencer: accept an operation, then execute it once the
// result register is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  logic           rsp_ready,
  output logic           rsp_valid,
  output spq_pkg::cmd_t  cmd
);
  import spq_pkg::*;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   can_exec;

  assign can_exec = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_EXEC;
      S_EXEC: if (can_exec) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready      = 1'b0;
    cmd            = '0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_EXEC: begin
        cmd.exec = can_exec;
        if (can_exec) rsp_valid_next = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> src/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Row of sorted cells, front at cell 0, with fill count and result register.
// ----------------------------------------------------------------------------
module spq_dp #(
  parameter int Depth  = spq_pkg::DEPTH_DEFAULT,
  parameter int CountW = $clog2(Depth + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spq_pkg::cmd_t                     cmd,
  input  logic [spq_pkg::MODE_W-1:0]        mode,
  input  logic signed [spq_pkg::PRIO_W-1:0] priority_in,
  input  logic [spq_pkg::TAG_W-1:0]         tag_in,
  output logic signed [spq_pkg::PRIO_W-1:0] priority_out,
  output logic [spq_pkg::TAG_W-1:0]         tag_out,
  output logic [CountW-1:0]                 count,
  output logic [spq_pkg::STATUS_W-1:0]      status
);
  import spq_pkg::*;

  // Captured operation
  mode_t                    op_mode;
  logic signed [PRIO_W-1:0] op_prio;
  logic [TAG_W-1:0]         op_tag;

  // Cell array, ascending priority from the front
  logic signed [PRIO_W-1:0] cell_prio [Depth];
  logic [TAG_W-1:0]         cell_tag  [Depth];
  logic [CountW-1:0]        fill;

  logic [Depth-1:0] ge;   // cell is invalid or not more urgent than new entry
  logic             is_full, is_empty, do_ins, do_del;

  // Next result beat
  logic signed [PRIO_W-1:0] priority_out_next;
  logic [TAG_W-1:0]         tag_out_next;
  logic [CountW-1:0]        count_next;
  status_t                  status_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= mode_t'(mode);
      op_prio <= priority_in;
      op_tag  <= tag_in;
    end
  end

  assign is_full  = (fill == CountW'(Depth));
  assign is_empty = (fill == '0);
  assign do_ins   = cmd.exec && (op_mode == MODE_ENQ) && !is_full;
  assign do_del   = cmd.exec && (op_mode == MODE_DEQ) && !is_empty;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign ge[i] = (CountW'(i) >= fill) || (cell_prio[i] >= op_prio);

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_ins && ge[i]) begin
          cell_prio[i] <= op_prio;
          cell_tag[i]  <= op_tag;
        end else if (do_del && Depth > 1) begin
          cell_prio[i] <= cell_prio[(i + 1) % Depth];
          cell_tag[i]  <= cell_tag[(i + 1) % Depth];
        end
      end
    end else if (i == Depth - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (do_ins && ge[i]) begin
          cell_prio[i] <= ge[i-1] ? cell_prio[i-1] : op_prio;
          cell_tag[i]  <= ge[i-1] ? cell_tag[i-1]  : op_tag;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (do_ins && ge[i]) begin
          cell_prio[i] <= ge[i-1] ? cell_prio[i-1] : op_prio;
          cell_tag[i]  <= ge[i-1] ? cell_tag[i-1]  : op_tag;
        end else if (do_del) begin
          cell_prio[i] <= cell_prio[i+1];
          cell_tag[i]  <= cell_tag[i+1];
        end
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.exec) begin
      unique case (op_mode)
        MODE_ENQ:   if (!is_full) fill <= fill + 1'b1;
        MODE_DEQ:   if (!is_empty) fill <= fill - 1'b1;
        MODE_PEEK:  ;
        MODE_CLEAR: fill <= '0;
        default:    ;
      endcase
    end
  end

  // Result beat for the operation being executed
  always_comb begin
    priority_out_next = '0;
    tag_out_next      = '0;
    status_next       = ST_OK;
    count_next        = fill;
    unique case (op_mode)
      MODE_ENQ: begin
        if (is_full) status_next = ST_FULL;
        else count_next = fill + 1'b1;
      end
      MODE_DEQ, MODE_PEEK: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          priority_out_next = cell_prio[0];
          tag_out_next      = cell_tag[0];
          if (op_mode == MODE_DEQ) count_next = fill - 1'b1;
        end
      end
      MODE_CLEAR: count_next = '0;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      priority_out <= priority_out_next;
      tag_out      <= tag_out_next;
      count        <= count_next;
      status       <= status_next;
    end
  end

endmodule

>>> src/sorted_priority_queue.sv
// A result becomes valid once its operation is accepted in idle and then executed.
// Idle and execute alternate, so a new operation is accepted only after the last
//   executes; execution waits only while the previous result is held downstream.
// Every operation, including insertion, completes within the execute state:
//   all cells compare against the new priority in parallel and shift at once.
// Reset (synchronous, active high) empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Fixed-capacity priority queue held as a sorted row of cells; the smallest
// signed Q16.16 priority sits in cell 0 and is served first, newest first
// among equal priorities.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int Depth  = spq_pkg::DEPTH_DEFAULT,
  parameter int CountW = $clog2(Depth + 1)
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  cmd_t cmd;

  // Sequencer: accept in idle, execute once the result register is free.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd)
  );

  // Cell row, fill count and result register.
  spq_dp #(
    .Depth  (Depth),
    .CountW (CountW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (req.mode),
    .priority_in  (req.priority_in),
    .tag_in       (req.tag_in),
    .priority_out (rsp.priority_out),
    .tag_out      (rsp.tag_out),
    .count        (rsp.count),
    .status       (rsp.status)
  );

endmodule
